// ===== src/pmoi_pkg.sv =====
// shared types and constants for the polygon moment of inertia block
`timescale 1ns / 1ps
package pmoi_pkg;

   localparam int COORD_W = 16;
   localparam int RES_W   = 48;
   localparam int CSR_W   = 32;
   localparam int IDX_W   = 2;

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] CSR_MASS     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_INFINITE = 2'd1;
   localparam logic [IDX_W-1:0] CSR_CENTER_X = 2'd2;
   localparam logic [IDX_W-1:0] CSR_CENTER_Y = 2'd3;

   localparam logic [CSR_W-1:0] MASS_RESET = 32'd65536;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic                      is_last_vertex;
   } req_type;

   typedef struct packed {
      logic [RES_W-1:0] inertia;
      logic [RES_W-1:0] inverse_inertia;
      logic             degenerate;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_MUL,
      ST_EDGE_SUM,
      ST_EDGE_PROD,
      ST_EDGE_ACC,
      ST_CLOSE,
      ST_FIN_LO,
      ST_FIN_HI,
      ST_FIN_NUM,
      ST_DIV_I_LOAD,
      ST_DIV_I,
      ST_INV_SETUP,
      ST_DIV_V,
      ST_INV_STORE,
      ST_OUT
   } state_type;

   // strobes from controller to datapath
   typedef struct packed {
      logic take_vertex;
      logic edge_mul;
      logic edge_sum;
      logic edge_prod;
      logic edge_acc;
      logic close_setup;
      logic fin_lo;
      logic fin_hi;
      logic fin_num;
      logic div_load_i;
      logic div_step;
      logic inv_setup;
      logic inv_store;
      logic out_load;
   } cmd_type;

   // flags from datapath to controller
   typedef struct packed {
      logic count_zero;
      logic last;
      logic closing;
      logic degen;
      logic div_last;
      logic skip_inverse;
      logic out_busy;
   } status_type;

endpackage

// ===== src/pmoi_ctrl.sv =====
// sequencing state machine for the polygon moment of inertia block
`timescale 1ns / 1ps
module pmoi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  pmoi_pkg::status_type  status,
   output pmoi_pkg::cmd_type     cmd
);

   pmoi_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmoi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmoi_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!status.count_zero) state_in = pmoi_pkg::ST_EDGE_MUL;
               else if (req_last)      state_in = pmoi_pkg::ST_CLOSE;
            end
         end
         pmoi_pkg::ST_EDGE_MUL:  state_in = pmoi_pkg::ST_EDGE_SUM;
         pmoi_pkg::ST_EDGE_SUM:  state_in = pmoi_pkg::ST_EDGE_PROD;
         pmoi_pkg::ST_EDGE_PROD: state_in = pmoi_pkg::ST_EDGE_ACC;
         pmoi_pkg::ST_EDGE_ACC: begin
            if (status.closing)   state_in = pmoi_pkg::ST_FIN_LO;
            else if (status.last) state_in = pmoi_pkg::ST_CLOSE;
            else                  state_in = pmoi_pkg::ST_IDLE;
         end
         pmoi_pkg::ST_CLOSE: state_in = pmoi_pkg::ST_EDGE_MUL;
         pmoi_pkg::ST_FIN_LO: begin
            if (status.degen) state_in = pmoi_pkg::ST_OUT;
            else              state_in = pmoi_pkg::ST_FIN_HI;
         end
         pmoi_pkg::ST_FIN_HI:     state_in = pmoi_pkg::ST_FIN_NUM;
         pmoi_pkg::ST_FIN_NUM:    state_in = pmoi_pkg::ST_DIV_I_LOAD;
         pmoi_pkg::ST_DIV_I_LOAD: state_in = pmoi_pkg::ST_DIV_I;
         pmoi_pkg::ST_DIV_I: begin
            if (status.div_last) state_in = pmoi_pkg::ST_INV_SETUP;
         end
         pmoi_pkg::ST_INV_SETUP: begin
            if (status.skip_inverse) state_in = pmoi_pkg::ST_OUT;
            else                     state_in = pmoi_pkg::ST_DIV_V;
         end
         pmoi_pkg::ST_DIV_V: begin
            if (status.div_last) state_in = pmoi_pkg::ST_INV_STORE;
         end
         pmoi_pkg::ST_INV_STORE: state_in = pmoi_pkg::ST_OUT;
         pmoi_pkg::ST_OUT: begin
            if (!status.out_busy) state_in = pmoi_pkg::ST_IDLE;
         end
         default: state_in = pmoi_pkg::ST_IDLE;
      endcase
   end

   // command strobes
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pmoi_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.take_vertex = req_valid;
         end
         pmoi_pkg::ST_EDGE_MUL:   cmd.edge_mul    = 1'b1;
         pmoi_pkg::ST_EDGE_SUM:   cmd.edge_sum    = 1'b1;
         pmoi_pkg::ST_EDGE_PROD:  cmd.edge_prod   = 1'b1;
         pmoi_pkg::ST_EDGE_ACC:   cmd.edge_acc    = 1'b1;
         pmoi_pkg::ST_CLOSE:      cmd.close_setup = 1'b1;
         pmoi_pkg::ST_FIN_LO:     cmd.fin_lo      = 1'b1;
         pmoi_pkg::ST_FIN_HI:     cmd.fin_hi      = 1'b1;
         pmoi_pkg::ST_FIN_NUM:    cmd.fin_num     = 1'b1;
         pmoi_pkg::ST_DIV_I_LOAD: cmd.div_load_i  = 1'b1;
         pmoi_pkg::ST_DIV_I:      cmd.div_step    = 1'b1;
         pmoi_pkg::ST_INV_SETUP:  cmd.inv_setup   = 1'b1;
         pmoi_pkg::ST_DIV_V:      cmd.div_step    = 1'b1;
         pmoi_pkg::ST_INV_STORE:  cmd.inv_store   = 1'b1;
         pmoi_pkg::ST_OUT:        cmd.out_load    = !status.out_busy;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== src/pmoi_dp.sv =====
// datapath: offsets, edge terms, accumulators, final multiply and divider
`timescale 1ns / 1ps
module pmoi_dp #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pmoi_pkg::req_type           req_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output pmoi_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [pmoi_pkg::IDX_W-1:0]  csr_index,
   input  logic [pmoi_pkg::CSR_W-1:0]  csr_wdata,
   input  pmoi_pkg::cmd_type           cmd,
   output pmoi_pkg::status_type        status
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 2);
   localparam int OFF_W = pmoi_pkg::COORD_W + 1;
   localparam int PRD_W = 2 * OFF_W;
   localparam int CR_W  = 34;
   localparam int D_W   = 35;
   localparam int WS_W  = 56;
   localparam int CS_W  = 40;
   localparam int TRM_W = 54;
   localparam int R_W   = pmoi_pkg::RES_W;
   localparam int NUM_W = 88;
   localparam int HLF_W = 28;
   localparam int PP_W  = pmoi_pkg::CSR_W + HLF_W;
   localparam int DC_W  = $clog2(R_W);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
   localparam logic [DC_W-1:0]  DC_LAST = DC_W'(R_W - 1);

   // configuration
   logic [pmoi_pkg::CSR_W-1:0]           mass_ff;
   logic                                 inf_ff;
   logic signed [pmoi_pkg::COORD_W-1:0]  cx_ff, cy_ff;

   // control state
   logic signed [OFF_W-1:0] fx_ff, fy_ff, px_ff, py_ff;
   logic [WS_W-1:0]         ws_ff;
   logic [CS_W-1:0]         cs_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    last_ff, closing_ff, rsp_valid_ff;
   logic [DC_W-1:0]         dcnt_ff;

   // payload
   logic signed [OFF_W-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PRD_W-1:0] pc0_ff, pc1_ff, pd0_ff, pd1_ff, pd2_ff, pd3_ff, pd4_ff, pd5_ff;
   logic [CR_W-1:0]         cr_ff;
   logic [D_W-1:0]          d_ff;
   logic [TRM_W-2:0]        m1_ff;
   logic [TRM_W-4:0]        m2_ff;
   logic [PP_W-1:0]         plo_ff, phi_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [R_W-1:0]          rem_ff, lo_ff, q_ff, dv_ff;
   logic                    sat_ff;
   logic [R_W-1:0]          inertia_ff, inverse_ff;
   logic                    degen_ff;
   pmoi_pkg::rsp_type       rsp_ff;

   logic signed [OFF_W-1:0] ox, oy;
   logic signed [PRD_W:0]   cdiff;
   logic signed [PRD_W+2:0] dsum;
   logic [TRM_W-1:0]        term;
   logic [WS_W:0]           ws_sum;
   logic [CS_W:0]           cs_sum;
   logic [R_W-1:0]          div_hi, div_res;
   logic [R_W:0]            div_sh;
   logic                    div_ge, degen_now;

   // vertex offset from the current centre
   assign ox = OFF_W'(req_data.vertex_x) - OFF_W'(cx_ff);
   assign oy = OFF_W'(req_data.vertex_y) - OFF_W'(cy_ff);

   // edge arithmetic
   assign cdiff  = (PRD_W+1)'(pc0_ff) - (PRD_W+1)'(pc1_ff);
   assign dsum   = (PRD_W+3)'(pd0_ff) + (PRD_W+3)'(pd1_ff) + (PRD_W+3)'(pd2_ff)
                 + (PRD_W+3)'(pd3_ff) + (PRD_W+3)'(pd4_ff) + (PRD_W+3)'(pd5_ff);
   assign term   = TRM_W'(m1_ff) + TRM_W'(m2_ff[TRM_W-4:16]);
   assign ws_sum = (WS_W+1)'(ws_ff) + (WS_W+1)'(term);
   assign cs_sum = (CS_W+1)'(cs_ff) + (CS_W+1)'(cr_ff);

   assign degen_now = (cs_ff == '0) || (cnt_ff > CNT_MAX);

   // divider step and result
   assign div_sh  = {rem_ff, lo_ff[R_W-1]};
   assign div_ge  = div_sh >= {1'b0, dv_ff};
   assign div_res = sat_ff ? {R_W{1'b1}} : q_ff;
   assign div_hi  = cmd.div_load_i ? R_W'(num_ff[NUM_W-1:R_W]) : R_W'(1);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= pmoi_pkg::MASS_RESET;
         inf_ff       <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         ws_ff        <= '0;
         cs_ff        <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         closing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               pmoi_pkg::CSR_MASS:     mass_ff <= csr_wdata;
               pmoi_pkg::CSR_INFINITE: inf_ff  <= csr_wdata[0];
               pmoi_pkg::CSR_CENTER_X: cx_ff   <= csr_wdata[pmoi_pkg::COORD_W-1:0];
               pmoi_pkg::CSR_CENTER_Y: cy_ff   <= csr_wdata[pmoi_pkg::COORD_W-1:0];
               default: ;
            endcase
         end
         if (cmd.take_vertex) begin
            if (cnt_ff == '0) begin
               fx_ff <= ox;
               fy_ff <= oy;
            end
            px_ff   <= ox;
            py_ff   <= oy;
            last_ff <= req_data.is_last_vertex;
            if (cnt_ff <= CNT_MAX) cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.close_setup) closing_ff <= 1'b1;
         if (cmd.edge_acc) begin
            ws_ff <= ws_sum[WS_W] ? {WS_W{1'b1}} : ws_sum[WS_W-1:0];
            cs_ff <= cs_sum[CS_W] ? {CS_W{1'b1}} : cs_sum[CS_W-1:0];
         end
         if (cmd.div_load_i || cmd.inv_setup) dcnt_ff <= '0;
         else if (cmd.div_step)               dcnt_ff <= dcnt_ff + 1'b1;
         // result transfer and clearing for the next polygon
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            fx_ff        <= '0;
            fy_ff        <= '0;
            px_ff        <= '0;
            py_ff        <= '0;
            ws_ff        <= '0;
            cs_ff        <= '0;
            cnt_ff       <= '0;
            last_ff      <= 1'b0;
            closing_ff   <= 1'b0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      // edge operands
      if (cmd.take_vertex) begin
         ax_ff <= px_ff;
         ay_ff <= py_ff;
         bx_ff <= ox;
         by_ff <= oy;
      end else if (cmd.close_setup) begin
         ax_ff <= px_ff;
         ay_ff <= py_ff;
         bx_ff <= fx_ff;
         by_ff <= fy_ff;
      end
      // cross and dot partial products
      if (cmd.edge_mul) begin
         pc0_ff <= ax_ff * by_ff;
         pc1_ff <= ay_ff * bx_ff;
         pd0_ff <= bx_ff * bx_ff;
         pd1_ff <= by_ff * by_ff;
         pd2_ff <= bx_ff * ax_ff;
         pd3_ff <= by_ff * ay_ff;
         pd4_ff <= ax_ff * ax_ff;
         pd5_ff <= ay_ff * ay_ff;
      end
      if (cmd.edge_sum) begin
         cr_ff <= cdiff[PRD_W] ? CR_W'(-cdiff) : CR_W'(cdiff);
         d_ff  <= D_W'(dsum);
      end
      if (cmd.edge_prod) begin
         m1_ff <= (TRM_W-1)'(cr_ff * d_ff[D_W-1:16]);
         m2_ff <= (TRM_W-3)'(cr_ff * d_ff[15:0]);
      end
      // mass times weighted sum in two halves
      if (cmd.fin_lo) begin
         plo_ff     <= mass_ff * ws_ff[HLF_W-1:0];
         degen_ff   <= degen_now;
         inertia_ff <= '0;
         inverse_ff <= '0;
      end
      if (cmd.fin_hi) phi_ff <= mass_ff * ws_ff[WS_W-1:HLF_W];
      if (cmd.fin_num) num_ff <= {phi_ff, {HLF_W{1'b0}}} + NUM_W'(plo_ff);
      // shared restoring divider
      if (cmd.div_load_i || (cmd.inv_setup && !status.skip_inverse)) begin
         if (cmd.div_load_i) begin
            dv_ff <= R_W'({cs_ff, 2'b00}) + R_W'({cs_ff, 1'b0});
            lo_ff <= num_ff[R_W-1:0];
            sat_ff <= div_hi >= (R_W'({cs_ff, 2'b00}) + R_W'({cs_ff, 1'b0}));
            rem_ff <= (div_hi >= (R_W'({cs_ff, 2'b00}) + R_W'({cs_ff, 1'b0})))
                      ? '0 : div_hi;
         end else begin
            dv_ff  <= div_res;
            lo_ff  <= '0;
            sat_ff <= div_hi >= div_res;
            rem_ff <= (div_hi >= div_res) ? '0 : div_hi;
         end
         q_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? R_W'(div_sh - {1'b0, dv_ff}) : div_sh[R_W-1:0];
         lo_ff  <= {lo_ff[R_W-2:0], 1'b0};
         q_ff   <= {q_ff[R_W-2:0], div_ge};
      end
      if (cmd.inv_setup) inertia_ff <= div_res;
      if (cmd.inv_store) inverse_ff <= div_res;
      if (cmd.out_load) begin
         rsp_ff.inertia         <= inertia_ff;
         rsp_ff.inverse_inertia <= inverse_ff;
         rsp_ff.degenerate      <= degen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the controller
   always_comb begin
      status.count_zero   = (cnt_ff == '0);
      status.last         = last_ff;
      status.closing      = closing_ff;
      status.degen        = degen_now;
      status.div_last     = (dcnt_ff == DC_LAST);
      status.skip_inverse = inf_ff || (div_res == '0);
      status.out_busy     = rsp_valid_ff && !rsp_ready;
   end

endmodule

// ===== src/polygon_moment_of_inertia.sv =====
// Polygon moment of inertia: sequencing
// An opening vertex is only accepted; each further vertex is accepted and then runs one
// edge pass (products, sums, weight product, accumulate) before the next. The last vertex
// adds the closing edge, final multiply, inertia divide and inverse divide (skipped for the
// infinite flag or zero inertia; none if degenerate). A held result stalls the next one.
// Reset is synchronous, active high: registers take their reset values, accumulators clear.
`timescale 1ns / 1ps
module polygon_moment_of_inertia #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pmoi_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pmoi_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [pmoi_pkg::IDX_W-1:0]  csr_index,
   input  logic [pmoi_pkg::CSR_W-1:0]  csr_wdata
);

   pmoi_pkg::cmd_type    cmd;
   pmoi_pkg::status_type status;

   // sequencer
   pmoi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last_vertex),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   pmoi_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef SYNTHESIS
   // a degenerate polygon carries zero values
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.inertia == '0 && rsp_data.inverse_inertia == '0)
      else $error("degenerate result with nonzero values");

   // zero inertia never has a nonzero inverse
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inertia == '0 |-> rsp_data.inverse_inertia == '0)
      else $error("inverse inertia nonzero for zero inertia");

   // a new result is only loaded once the previous one has been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pending result overwritten");
`endif

endmodule
